// ===== rtl/core/tss_pkg.sv =====
`timescale 1ns / 1ps

package tss_pkg;

    // peer table depth
    localparam int MAX_PEERS = 8;
    localparam int PIDX_W    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);

    localparam int ID_W      = 64;
    localparam int TIME_W    = 32;
    localparam int LEN_W     = 16;
    localparam int PTOT_W    = 8;
    localparam int SLOT_W    = 4;
    // slot length times slot count (16 x 9 bits)
    localparam int FRAME_W   = LEN_W + PTOT_W + 1;

    localparam logic [LEN_W-1:0]  SLOT_LEN_RST  = LEN_W'(50);
    localparam logic [LEN_W-1:0]  GAP_LEN_RST   = LEN_W'(5);
    localparam logic [TIME_W-1:0] BCN_INTVL_RST = TIME_W'(1000);

    // config register byte addresses
    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_OWN_ID    = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_BCN_INTVL = 4'h8;

    typedef enum logic [1:0] {
        ACT_LISTEN  = 2'd0,
        ACT_BEACON  = 2'd1,
        ACT_PAYLOAD = 2'd2,
        ACT_ABSORB  = 2'd3
    } tss_action_t;

    typedef enum logic {
        PASS_SEARCH = 1'b0,
        PASS_COUNT  = 1'b1
    } tss_pass_t;

    // accumulator handed from cell to cell
    typedef struct packed {
        tss_pass_t          pass;
        logic               hit;
        logic               free_found;
        logic [PIDX_W-1:0]  free_idx;
        logic [CNT_W-1:0]   count;
        logic [ID_W-1:0]    top;
    } tss_acc_t;

endpackage

// ===== rtl/core/tss_ifs.sv =====
`timescale 1ns / 1ps

interface tss_req_if import tss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [TIME_W-1:0] now_time;
    logic [ID_W-1:0]   adv_peer_id;
    logic [LEN_W-1:0]  adv_slot_length;
    logic [LEN_W-1:0]  adv_guard_gap;
    logic [PTOT_W-1:0] adv_peer_total;
    logic [TIME_W-1:0] adv_sender_time;

    modport source (output valid, mode, now_time, adv_peer_id, adv_slot_length,
                    adv_guard_gap, adv_peer_total, adv_sender_time, input ready);
    modport sink   (input valid, mode, now_time, adv_peer_id, adv_slot_length,
                    adv_guard_gap, adv_peer_total, adv_sender_time, output ready);
endinterface

interface tss_rsp_if import tss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic              in_own_slot;
    logic [SLOT_W-1:0] slot_number;
    logic [PTOT_W-1:0] known_peers;
    logic [LEN_W-1:0]  slot_length;
    logic [LEN_W-1:0]  guard_gap;
    logic [TIME_W-1:0] beacon_time;
    logic              peer_added;
    logic              table_full;

    modport source (output valid, action, in_own_slot, slot_number, known_peers,
                    slot_length, guard_gap, beacon_time, peer_added, table_full,
                    input ready);
    modport sink   (input valid, action, in_own_slot, slot_number, known_peers,
                    slot_length, guard_gap, beacon_time, peer_added, table_full,
                    output ready);
endinterface

// ===== rtl/core/tss_peer_cell.sv =====
`timescale 1ns / 1ps

module tss_peer_cell
    import tss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PIDX_W-1:0] cell_idx,
    input  logic [ID_W-1:0]   sender,
    input  logic [ID_W-1:0]   own_id,
    input  logic              alloc_en,
    input  logic [PIDX_W-1:0] alloc_idx,
    input  logic              tok_in,
    input  tss_acc_t          acc_in,
    output logic              tok_out,
    output tss_acc_t          acc_out
);

    logic            valid_reg;
    logic [ID_W-1:0] ident_reg;
    logic            tok_reg;
    tss_acc_t        acc_reg;
    tss_acc_t        acc_next;

    always_comb
    begin
        acc_next = acc_in;
        case (acc_in.pass)
            PASS_SEARCH:
            begin
                if (valid_reg)
                begin
                    if (ident_reg == sender)
                        acc_next.hit = 1'b1;
                end
                else if (!acc_in.free_found && !acc_in.hit)
                begin
                    acc_next.free_found = 1'b1;
                    acc_next.free_idx   = cell_idx;
                end
            end
            PASS_COUNT:
            begin
                if (valid_reg)
                begin
                    if (ident_reg > own_id)
                        acc_next.count = acc_in.count + CNT_W'(1);
                    if (ident_reg > acc_in.top)
                        acc_next.top = ident_reg;
                end
            end
            default: acc_next = acc_in;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (alloc_en && (alloc_idx == cell_idx))
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (alloc_en && (alloc_idx == cell_idx))
            ident_reg <= sender;
    end

    assign tok_out = tok_reg;
    assign acc_out = acc_reg;

endmodule

// ===== rtl/core/tss_mod_unit.sv =====
`timescale 1ns / 1ps

module tss_mod_unit
    import tss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TIME_W-1:0]  dividend,
    input  logic [FRAME_W-1:0] divisor,
    output logic               done,
    output logic [FRAME_W-1:0] rem
);

    localparam int CW = $clog2(TIME_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [TIME_W-1:0]  dvd_reg;
    logic [FRAME_W-1:0] rem_reg;
    logic [FRAME_W:0]   trial;
    logic [FRAME_W:0]   diff;

    // restoring step: one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(TIME_W);
                dvd_reg  <= dividend;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                    rem_reg <= diff[FRAME_W-1:0];
                else
                    rem_reg <= trial[FRAME_W-1:0];
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/tdma_slot_scheduler.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake     | Payload
// req      | in  | valid/ready   | mode, now_time, adv_* fields
// rsp      | out | valid/ready   | action, slot info, beacon_time, table flags
// apb      | in  | psel/penable  | own_node_id @0x0, bcn_intvl @0x8
//
// One item at a time. A tick with a nonzero slot length runs through the
// 32-step restoring modulo unit. An advertisement makes two token passes
// down the peer cell chain (search, then count/max).
// Reset is asynchronous; the peer table valid bits clear at once.
// A result waiting in the output register holds off the next item.

module tdma_slot_scheduler
    import tss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tss_req_if.sink           req,
    tss_rsp_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TFRAME,
        S_TMODGO,
        S_TMOD,
        S_SGO,
        S_SWAIT,
        S_CGO,
        S_CWAIT
    } state_t;

    state_t state_reg;

    // config
    logic [ID_W-1:0]   own_id_reg;
    logic [TIME_W-1:0] bcn_intvl_reg;

    // scheduler state
    logic [PTOT_W-1:0] peer_total_reg;
    logic [SLOT_W-1:0] own_slot_reg;
    logic [LEN_W-1:0]  slot_len_reg;
    logic [LEN_W-1:0]  gap_len_reg;
    logic [TIME_W-1:0] time_offset_reg;
    logic [TIME_W-1:0] last_bcn_reg;
    logic [TIME_W-1:0] net_time_reg;

    // latched item
    logic [TIME_W-1:0] now_reg;
    logic [ID_W-1:0]   sender_reg;
    logic [LEN_W-1:0]  a_len_reg;
    logic [LEN_W-1:0]  a_gap_reg;
    logic [PTOT_W-1:0] a_ptot_reg;
    logic [TIME_W-1:0] a_stime_reg;
    logic              added_reg;

    // tick datapath
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] start_pos_reg;
    logic [PTOT_W:0]    slots;
    logic               mod_done;
    logic [FRAME_W-1:0] mod_rem;
    logic               hit_win;

    // result register
    logic              rsp_valid_reg;
    tss_action_t       r_action_reg;
    logic              r_inslot_reg;
    logic [SLOT_W-1:0] r_slot_reg;
    logic [PTOT_W-1:0] r_peers_reg;
    logic [LEN_W-1:0]  r_len_reg;
    logic [LEN_W-1:0]  r_gap_reg;
    logic [TIME_W-1:0] r_btime_reg;
    logic              r_added_reg;
    logic              r_full_reg;

    // cell chain
    logic     tok_w [MAX_PEERS+1];
    tss_acc_t acc_w [MAX_PEERS+1];
    logic     alloc_en;
    logic [PIDX_W-1:0] alloc_idx;
    tss_acc_t chain_res;

    logic accept;
    logic cfg_wr;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr)
            ADDR_OWN_ID:    prdata = own_id_reg;
            ADDR_BCN_INTVL: prdata = {32'd0, bcn_intvl_reg};
            default:        prdata = '0;
        endcase
    end

    // token launch into cell 0; pass kind follows the state
    always_comb
    begin
        tok_w[0]            = (state_reg == S_SGO) || (state_reg == S_CGO);
        acc_w[0].pass       = (state_reg == S_CGO) ? PASS_COUNT : PASS_SEARCH;
        acc_w[0].hit        = 1'b0;
        acc_w[0].free_found = 1'b0;
        acc_w[0].free_idx   = '0;
        acc_w[0].count      = '0;
        acc_w[0].top        = own_id_reg;
    end

    assign chain_res = acc_w[MAX_PEERS];

    // allocate the first free entry after a miss in the search pass
    assign alloc_en  = (state_reg == S_SWAIT) && tok_w[MAX_PEERS] &&
                       !chain_res.hit && chain_res.free_found;
    assign alloc_idx = chain_res.free_idx;

    genvar k;
    generate
        for (k = 0; k < MAX_PEERS; k++)
        begin : g_cell
            tss_peer_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (PIDX_W'(k)),
                .sender    (sender_reg),
                .own_id    (own_id_reg),
                .alloc_en  (alloc_en),
                .alloc_idx (alloc_idx),
                .tok_in    (tok_w[k]),
                .acc_in    (acc_w[k]),
                .tok_out   (tok_w[k+1]),
                .acc_out   (acc_w[k+1])
            );
        end
    endgenerate

    // frame has at least two slots
    assign slots = (peer_total_reg == '0) ? (PTOT_W+1)'(2)
                                          : {1'b0, peer_total_reg} + (PTOT_W+1)'(1);

    tss_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_TMODGO),
        .dividend (net_time_reg),
        .divisor  (frame_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // window: start <= pos and pos + gap <= start + len
    assign hit_win = ({1'b0, mod_rem} >= {1'b0, start_pos_reg}) &&
                     (({1'b0, mod_rem} + (FRAME_W+1)'(gap_len_reg)) <=
                      ({1'b0, start_pos_reg} + (FRAME_W+1)'(slot_len_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            own_id_reg      <= '0;
            bcn_intvl_reg   <= BCN_INTVL_RST;
            peer_total_reg  <= '0;
            own_slot_reg    <= '0;
            slot_len_reg    <= SLOT_LEN_RST;
            gap_len_reg     <= GAP_LEN_RST;
            time_offset_reg <= '0;
            last_bcn_reg    <= '0;
            net_time_reg    <= '0;
            now_reg         <= '0;
            sender_reg      <= '0;
            a_len_reg       <= '0;
            a_gap_reg       <= '0;
            a_ptot_reg      <= '0;
            a_stime_reg     <= '0;
            added_reg       <= 1'b0;
            frame_reg       <= '0;
            start_pos_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
            r_action_reg    <= ACT_LISTEN;
            r_inslot_reg    <= 1'b0;
            r_slot_reg      <= '0;
            r_peers_reg     <= '0;
            r_len_reg       <= '0;
            r_gap_reg       <= '0;
            r_btime_reg     <= '0;
            r_added_reg     <= 1'b0;
            r_full_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr)
                    ADDR_OWN_ID:    own_id_reg    <= pwdata;
                    ADDR_BCN_INTVL: bcn_intvl_reg <= pwdata[TIME_W-1:0];
                    default:        ;
                endcase
            end

            if (rsp.valid && rsp.ready)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg     <= req.now_time;
                        sender_reg  <= req.adv_peer_id;
                        a_len_reg   <= req.adv_slot_length;
                        a_gap_reg   <= req.adv_guard_gap;
                        a_ptot_reg  <= req.adv_peer_total;
                        a_stime_reg <= req.adv_sender_time;
                        added_reg   <= 1'b0;
                        if (req.mode)
                            state_reg <= S_SGO;
                        else
                        begin
                            net_time_reg <= req.now_time + time_offset_reg;
                            state_reg    <= S_TFRAME;
                        end
                    end
                end

                S_TFRAME:
                begin
                    frame_reg     <= FRAME_W'(slot_len_reg) * FRAME_W'(slots);
                    start_pos_reg <= FRAME_W'(slot_len_reg) * FRAME_W'(own_slot_reg);
                    if (slot_len_reg == '0)
                    begin
                        // zero slot length: never in own slot
                        rsp_valid_reg <= 1'b1;
                        r_action_reg  <= ACT_LISTEN;
                        r_inslot_reg  <= 1'b0;
                        r_slot_reg    <= own_slot_reg;
                        r_peers_reg   <= peer_total_reg;
                        r_len_reg     <= slot_len_reg;
                        r_gap_reg     <= gap_len_reg;
                        r_btime_reg   <= now_reg;
                        r_added_reg   <= 1'b0;
                        r_full_reg    <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_TMODGO;
                end

                S_TMODGO: state_reg <= S_TMOD;

                S_TMOD:
                begin
                    if (mod_done)
                    begin
                        rsp_valid_reg <= 1'b1;
                        r_inslot_reg  <= hit_win;
                        r_slot_reg    <= own_slot_reg;
                        r_peers_reg   <= peer_total_reg;
                        r_len_reg     <= slot_len_reg;
                        r_gap_reg     <= gap_len_reg;
                        r_btime_reg   <= now_reg;
                        r_added_reg   <= 1'b0;
                        r_full_reg    <= 1'b0;
                        if (!hit_win)
                            r_action_reg <= ACT_LISTEN;
                        else if ((now_reg - last_bcn_reg) >= bcn_intvl_reg)
                        begin
                            r_action_reg <= ACT_BEACON;
                            last_bcn_reg <= now_reg;
                        end
                        else
                            r_action_reg <= ACT_PAYLOAD;
                        state_reg <= S_IDLE;
                    end
                end

                S_SGO: state_reg <= S_SWAIT;

                S_SWAIT:
                begin
                    if (tok_w[MAX_PEERS])
                    begin
                        r_full_reg <= !chain_res.hit && !chain_res.free_found;
                        if (alloc_en)
                        begin
                            added_reg <= 1'b1;
                            if (peer_total_reg != '1)
                                peer_total_reg <= peer_total_reg + PTOT_W'(1);
                        end
                        state_reg <= S_CGO;
                    end
                end

                S_CGO: state_reg <= S_CWAIT;

                S_CWAIT:
                begin
                    if (tok_w[MAX_PEERS])
                    begin
                        // sender holds the largest id: adopt its schedule
                        if (sender_reg >= chain_res.top)
                        begin
                            slot_len_reg   <= a_len_reg;
                            gap_len_reg    <= a_gap_reg;
                            peer_total_reg <= a_ptot_reg;
                            r_len_reg      <= a_len_reg;
                            r_gap_reg      <= a_gap_reg;
                            r_peers_reg    <= a_ptot_reg;
                        end
                        else
                        begin
                            r_len_reg   <= slot_len_reg;
                            r_gap_reg   <= gap_len_reg;
                            r_peers_reg <= peer_total_reg;
                        end
                        // own id largest wins over adopting the sender's time offset
                        if (chain_res.top == own_id_reg)
                            time_offset_reg <= '0;
                        else if (sender_reg >= chain_res.top)
                            time_offset_reg <= a_stime_reg - now_reg;
                        own_slot_reg  <= SLOT_W'(chain_res.count);
                        rsp_valid_reg <= 1'b1;
                        r_action_reg  <= ACT_ABSORB;
                        r_inslot_reg  <= 1'b0;
                        r_slot_reg    <= SLOT_W'(chain_res.count);
                        r_btime_reg   <= '0;
                        r_added_reg   <= added_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.action      = r_action_reg;
    assign rsp.in_own_slot = r_inslot_reg;
    assign rsp.slot_number = r_slot_reg;
    assign rsp.known_peers = r_peers_reg;
    assign rsp.slot_length = r_len_reg;
    assign rsp.guard_gap   = r_gap_reg;
    assign rsp.beacon_time = r_btime_reg;
    assign rsp.peer_added  = r_added_reg;
    assign rsp.table_full  = r_full_reg;

endmodule

// ===== rtl/core/tss_checker.sv =====
`timescale 1ns / 1ps

module tss_checker
    import tss_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [1:0]        action,
    input logic              in_own_slot,
    input logic [TIME_W-1:0] beacon_time,
    input logic              peer_added,
    input logic              table_full
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    a_absorb_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (action == ACT_ABSORB) |-> !in_own_slot && (beacon_time == '0))
        else $error("advertisement result carries tick fields");

    a_tick_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (action != ACT_ABSORB) |-> !peer_added && !table_full)
        else $error("tick result carries table flags");

    a_slot_action: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (action != ACT_ABSORB) |->
            (in_own_slot == ((action == ACT_BEACON) || (action == ACT_PAYLOAD))))
        else $error("action disagrees with slot window");

    a_add_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(peer_added && table_full))
        else $error("entry added and table full together");

endmodule

bind tdma_slot_scheduler tss_checker u_tss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .action      (rsp.action),
    .in_own_slot (rsp.in_own_slot),
    .beacon_time (rsp.beacon_time),
    .peer_added  (rsp.peer_added),
    .table_full  (rsp.table_full)
);

// ===== dv/tss_tb_ifs.sv =====
`timescale 1ns / 1ps

// Testbench-side copies are not needed: the RTL interfaces tss_req_if and
// tss_rsp_if are used directly. This file holds the APB bundle for the bench.
interface tss_apb_if import tss_pkg::*; ();
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;
endinterface

// ===== dv/tss_checker.sv =====
`timescale 1ns / 1ps

module tss_scoreboard
    import tss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tss_req_if.sink    req,
    tss_rsp_if.sink    rsp,
    tss_apb_if         apb,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [1:0]        action;
        logic              in_own_slot;
        logic [SLOT_W-1:0] slot_number;
        logic [PTOT_W-1:0] known_peers;
        logic [LEN_W-1:0]  slot_length;
        logic [LEN_W-1:0]  guard_gap;
        logic [TIME_W-1:0] beacon_time;
        logic              peer_added;
        logic              table_full;
    } sched_out_t;

    sched_out_t expected_q[$];

    logic [ID_W-1:0]   node_id;
    logic [TIME_W-1:0] bcn_interval;
    logic              pv[MAX_PEERS];
    logic [ID_W-1:0]   pid[MAX_PEERS];
    logic [PTOT_W-1:0] npeers;
    logic [SLOT_W-1:0] my_slot;
    logic [LEN_W-1:0]  slen;
    logic [LEN_W-1:0]  glen;
    logic [TIME_W-1:0] toffs;
    logic [TIME_W-1:0] last_bcn;

    assign pending = expected_q.size();

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
        fail_count++;
    endtask

    function automatic bit in_window(input logic [TIME_W-1:0] nt);
        longint unsigned slots, frame, pos, start;
        slots = longint'(npeers) + 1;
        if (slots == 1) slots = 2;
        if (slen == 0) return 0;
        frame = longint'(slen) * slots;
        pos   = longint'(nt) % frame;
        start = longint'(slen) * longint'(my_slot);
        return pos >= start && pos + longint'(glen) <= start + longint'(slen);
    endfunction

    function automatic sched_out_t schedule_item();
        sched_out_t r;
        logic [TIME_W-1:0] now;
        int hit, freei, cnt;
        logic [ID_W-1:0] top;
        r = '0;
        now = req.now_time;
        if (req.mode == 1'b0) begin
            if (in_window(now + toffs)) begin
                r.in_own_slot = 1;
                if (TIME_W'(now - last_bcn) >= bcn_interval) begin
                    last_bcn = now;
                    r.action = ACT_BEACON;
                end
                else r.action = ACT_PAYLOAD;
            end
            else r.action = ACT_LISTEN;
            r.beacon_time = now;
        end
        else begin
            hit = -1; freei = -1; cnt = 0; top = node_id;
            for (int i = 0; i < MAX_PEERS; i++)
            begin
                if (pv[i]) begin
                    if (pid[i] == req.adv_peer_id) begin hit = i; break; end
                end
                else if (freei < 0) freei = i;
            end
            if (hit < 0) begin
                if (freei >= 0) begin
                    pv[freei] = 1; pid[freei] = req.adv_peer_id;
                    if (npeers != 8'hff) npeers++;
                    r.peer_added = 1;
                end
                else r.table_full = 1;
            end
            for (int i = 0; i < MAX_PEERS; i++)
                if (pv[i]) begin
                    if (pid[i] > node_id) cnt++;
                    if (pid[i] > top) top = pid[i];
                end
            if (req.adv_peer_id >= top) begin
                slen = req.adv_slot_length;
                glen = req.adv_guard_gap;
                npeers = req.adv_peer_total;
                toffs = req.adv_sender_time - now;
            end
            if (top == node_id) toffs = 0;
            my_slot = SLOT_W'(cnt);
            r.action = ACT_ABSORB;
        end
        r.slot_number = my_slot;
        r.known_peers = npeers;
        r.slot_length = slen;
        r.guard_gap   = glen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_out_t e;
        if (!rst_n) begin
            fail_count = 0;
            expected_q.delete();
            node_id = '0; bcn_interval = BCN_INTVL_RST;
            for (int i = 0; i < MAX_PEERS; i++) pv[i] = 0;
            npeers = 0; my_slot = 0; slen = SLOT_LEN_RST; glen = GAP_LEN_RST;
            toffs = 0; last_bcn = 0;
        end
        else begin
            if (apb.psel && apb.penable && apb.pwrite && apb.pready) begin
                if (apb.paddr == ADDR_OWN_ID) node_id = apb.pwdata;
                else if (apb.paddr == ADDR_BCN_INTVL) bcn_interval = apb.pwdata[31:0];
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_q.size() == 0) report("unexpected item", 0, 0);
                else begin
                    e = expected_q.pop_front();
                    if (rsp.action != e.action) report("action", rsp.action, e.action);
                    if (rsp.in_own_slot != e.in_own_slot)
                        report("in_own_slot", rsp.in_own_slot, e.in_own_slot);
                    if (rsp.slot_number != e.slot_number)
                        report("slot_number", rsp.slot_number, e.slot_number);
                    if (rsp.known_peers != e.known_peers)
                        report("known_peers", rsp.known_peers, e.known_peers);
                    if (rsp.slot_length != e.slot_length)
                        report("slot_length", rsp.slot_length, e.slot_length);
                    if (rsp.guard_gap != e.guard_gap)
                        report("guard_gap", rsp.guard_gap, e.guard_gap);
                    if (rsp.beacon_time != e.beacon_time)
                        report("beacon_time", rsp.beacon_time, e.beacon_time);
                    if (rsp.peer_added != e.peer_added)
                        report("peer_added", rsp.peer_added, e.peer_added);
                    if (rsp.table_full != e.table_full)
                        report("table_full", rsp.table_full, e.table_full);
                end
            end
            if (req.valid && req.ready) expected_q.push_back(schedule_item());
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tss_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   idle_pct = 23;     // 0 during the burst stretch
    int   rsp_idle_pct = 23;

    localparam int CYCLE_LIMIT = 400000;

    tss_req_if req();
    tss_rsp_if rsp();
    tss_apb_if apb();

    tdma_slot_scheduler u_dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite),
        .paddr(apb.paddr), .pwdata(apb.pwdata), .prdata(apb.prdata),
        .pready(apb.pready)
    );

    tss_scoreboard u_chk (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.sink), .apb(apb),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL tdma_slot_scheduler");
            $finish;
        end
    end

    // response side back-pressure, changes on the falling edge
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);

    // small pool of ids so table hits, misses and fills all happen
    logic [ID_W-1:0] id_pool[12];

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [63:0] data);
        @(negedge clk);
        apb.psel <= 1; apb.penable <= 0; apb.pwrite <= 1;
        apb.paddr <= addr; apb.pwdata <= data;
        @(negedge clk);
        apb.penable <= 1;
        @(negedge clk);
        apb.psel <= 0; apb.penable <= 0; apb.pwrite <= 0;
    endtask

    // send one item; valid held until accepted
    task automatic send(input logic m, input logic [31:0] now, input logic [63:0] id,
                        input logic [15:0] sl, input logic [15:0] gg,
                        input logic [7:0] pt, input logic [31:0] st);
        while ($urandom_range(99) < idle_pct) @(negedge clk);
        req.valid = 1; req.mode = m; req.now_time = now; req.adv_peer_id = id;
        req.adv_slot_length = sl; req.adv_guard_gap = gg;
        req.adv_peer_total = pt; req.adv_sender_time = st;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
        req.valid = 0;
    endtask

    task automatic send_tick(input logic [31:0] now);
        send(0, now, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
             8'($urandom), $urandom);
    endtask

    task automatic send_adv(input logic [63:0] id, input logic [15:0] sl,
                            input logic [15:0] gg, input logic [7:0] pt,
                            input logic [31:0] now, input logic [31:0] st);
        send(1, now, id, sl, gg, pt, st);
    endtask

    // let everything drain, then wait at least the longest item time before touching config
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic random_phase(input int n, input logic [31:0] base);
        logic [31:0] t;
        logic [15:0] sl;
        t = base;
        for (int i = 0; i < n; i++)
        begin
            idle_pct = (i >= n/3 && i < n/3 + 40) ? 0 : 23;
            rsp_idle_pct = idle_pct;
            if ($urandom_range(99) < 25) begin
                sl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
                send_adv(id_pool[$urandom_range(11)], sl,
                         ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(sl)),
                         ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(9)),
                         ($urandom_range(9) == 0) ? $urandom : t, $urandom);
            end
            else begin
                t = ($urandom_range(19) == 0) ? $urandom : t + $urandom_range(1, 40);
                send_tick(t);
            end
        end
    endtask

    initial
    begin
        req.valid = 0; req.mode = 0; req.now_time = 0; req.adv_peer_id = 0;
        req.adv_slot_length = 1; req.adv_guard_gap = 0; req.adv_peer_total = 0;
        req.adv_sender_time = 0;
        rsp.ready = 0;
        apb.psel = 0; apb.penable = 0; apb.pwrite = 0; apb.paddr = '0; apb.pwdata = '0;
        for (int i = 0; i < 12; i++) id_pool[i] = {$urandom, $urandom};
        id_pool[0] = '0;
        id_pool[1] = '1;
        id_pool[2] = 64'h8000_0000_0000_0000;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: reset settings, ticks around the own window
        send_tick(0);
        send_tick(45);
        send_tick(46);
        send_tick(32'hffff_ffff);
        send_tick(1000);
        // own id equals a sender id, largest-id adoption, zero slot length
        drain();
        apb_write(ADDR_OWN_ID, 64'h0000_0000_0000_0100);
        apb_write(ADDR_BCN_INTVL, 64'h0);
        send_adv(64'h100, 16'd20, 16'd2, 8'd3, 32'd10, 32'd500);
        send_adv(64'h50, 16'd30, 16'd3, 8'd1, 32'd10, 32'd500);
        send_adv('1, 16'hffff, 16'hffff, 8'hff, 32'hffff_ffff, 32'h0);
        send_tick(32'h1234);
        send_adv('1, 16'd0, 16'd0, 8'd0, 32'd0, 32'hffff_ffff);
        send_tick(32'h10);
        // guard gap longer than slot
        send_adv('1, 16'd10, 16'd11, 8'd0, 32'd0, 32'd0);
        send_tick(32'd0);
        // fill the table and overflow it
        for (int i = 0; i < 10; i++)
            send_adv(64'h1000 + i, 16'd40, 16'd4, 8'd255, 32'd7, 32'($urandom));
        send_tick(32'd5);

        // pause until every result is in
        drain();
        apb_write(ADDR_OWN_ID, '1);
        apb_write(ADDR_BCN_INTVL, 64'hffff_ffff);
        random_phase(150, 32'h0);

        drain();
        apb_write(ADDR_OWN_ID, {$urandom, $urandom});
        apb_write(ADDR_BCN_INTVL, 64'd50);
        random_phase(250, $urandom);

        drain();
        apb_write(ADDR_OWN_ID, '0);
        apb_write(ADDR_BCN_INTVL, 64'd1);
        random_phase(250, 32'hffff_ff00);

        drain();
        if (fail_count == 0)
            $display("PASS tdma_slot_scheduler");
        else
            $display("FAIL tdma_slot_scheduler");
        $finish;
    end

endmodule
